>>> sv/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg - shared types and constants for the min/max contrast stretch
// Controller states, command/status bundles and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mmcs_pkg;

  localparam int DEF_FRAME_DEPTH = 64;
  localparam int SAMPLE_W        = 32;
  localparam int PIXEL_W         = 8;
  // (x-min)*255 fits in 40 bits for a 32-bit span
  localparam int NUM_W           = SAMPLE_W + PIXEL_W;
  localparam int STEP_W          = $clog2(PIXEL_W);
  localparam int Q_MID           = 128;

  localparam logic MODE_PLAIN  = 1'b0;
  localparam logic MODE_INVERT = 1'b1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_DIFF,
    S_SCALE,
    S_DIV,
    S_FMT,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;        // input beat accepted
    logic emit_start;  // accepted beat carries tlast
    logic rd;          // read buffer entry, latch span
    logic sub;         // x - min
    logic scale;       // numerator = diff * 255, start divider
    logic step;        // one quotient bit
    logic fmt;         // format result into output register
    logic beat_done;   // result beat taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_elem;   // current emit index is the frame's last entry
    logic div_done;    // divider on its final bit
  } sts_t;

endpackage

`default_nettype wire

>>> sv/min_max_contrast_stretch.sv
// ----------------------------------------------------------------------------
// min_max_contrast_stretch - frame min/max normalization to 8-bit pixels
// Buffers a frame of Q16.16 samples, then emits each stretched to a byte.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream in_*: one signed Q16.16 sample per beat, tlast marks the
//    frame's final sample. Loading takes one beat per cycle.
//  - Up to FRAME_DEPTH samples are stored; extra ones are dropped (not in
//    min/max) but their tlast still closes the frame.
//  - After the tlast beat, in_tready drops and every stored sample is put
//    out on out_* in load order; out_tlast marks the frame's last pixel.
//  - Each result passes through buffer read, subtract, scale by 255, a
//    restoring divide (one quotient bit per cycle), format and the
//    output beat. The divider bounds the emit rate.
//  - A stalled receiver holds the current pixel; the sequencer waits.
//  - cfg_wr_en/cfg_wr_data set output_mode (0 plain, 1 inverted signed);
//    write only while idle.
//  - Synchronous active-low reset: mode 0, empty frame, ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_contrast_stretch
  import mmcs_pkg::*;
#(
  parameter int FRAME_DEPTH = DEF_FRAME_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input stream
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic signed [SAMPLE_W-1:0] in_tdata,   // [31:0] sample
  input  wire logic                       in_tlast,   // last_sample
  // result stream
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic             [PIXEL_W-1:0]  out_tdata,  // [7:0] pixel
  output logic                            out_tlast,  // last_pixel
  // configuration
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_wr_data // output_mode
);

  cmd_t cmd;
  sts_t sts;

  mmcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mmcs_dp #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

>>> sv/mmcs_ram.sv
// ----------------------------------------------------------------------------
// mmcs_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/mmcs_ctrl.sv
// ----------------------------------------------------------------------------
// mmcs_ctrl - sequencer for load and emit phases
// Accepts samples in LOAD; per stored sample walks read, subtract, scale, divide, format, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcs_ctrl
  import mmcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tlast,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (in_tvalid && in_tlast) state_nxt = S_READ;
      S_READ:  state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_DIV;
      S_DIV:   if (sts.div_done) state_nxt = S_FMT;
      S_FMT:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) state_nxt = sts.last_elem ? S_LOAD : S_READ;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == S_LOAD);
    out_tvalid     = (state_r == S_OUT);
    cmd            = '0;
    cmd.take       = (state_r == S_LOAD) && in_tvalid;
    cmd.emit_start = (state_r == S_LOAD) && in_tvalid && in_tlast;
    cmd.rd         = (state_r == S_READ);
    cmd.sub        = (state_r == S_DIFF);
    cmd.scale      = (state_r == S_SCALE);
    cmd.step       = (state_r == S_DIV);
    cmd.fmt        = (state_r == S_FMT);
    cmd.beat_done  = (state_r == S_OUT) && out_tready;
  end

endmodule

`default_nettype wire

>>> sv/mmcs_dp.sv
// ----------------------------------------------------------------------------
// mmcs_dp - frame buffer, min/max tracking and stretch arithmetic
// Restoring divider produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcs_dp
  import mmcs_pkg::*;
#(
  parameter int FRAME_DEPTH = DEF_FRAME_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cmd_t                       cmd,
  output sts_t                            sts,
  input  wire logic signed [SAMPLE_W-1:0] in_tdata,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_wr_data,
  output logic             [PIXEL_W-1:0]  out_tdata,
  output logic                            out_tlast
);

  localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  logic [CW-1:0]        count_r, idx_r;
  logic                 mode_r;
  logic [SAMPLE_W-1:0]  min_r, max_r, span_r, diff_r;
  logic [SAMPLE_W-1:0]  rd_data;
  logic [NUM_W-1:0]     rem_r, trial;
  logic [PIXEL_W-1:0]   q_r;
  logic [STEP_W-1:0]    k_r;
  logic                 store;
  logic                 q_bit;
  logic [PIXEL_W:0]     t_val;
  logic                 t_inc;
  logic [PIXEL_W-1:0]   pix;

  assign store = cmd.take && (count_r < CW'(FRAME_DEPTH));

  mmcs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (store),
    .waddr (count_r[AW-1:0]),
    .wdata (in_tdata),
    .re    (cmd.rd),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // control counters and mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      mode_r  <= MODE_PLAIN;
      k_r     <= '0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (store) count_r <= count_r + CW'(1);
      if (cmd.emit_start) idx_r <= '0;
      if (cmd.beat_done) begin
        if (sts.last_elem) begin
          count_r <= '0;
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      if (cmd.scale) k_r <= STEP_W'(PIXEL_W - 1);
      else if (cmd.step) k_r <= k_r - STEP_W'(1);
    end
  end

  // min/max: first sample of a frame seeds both
  always_ff @(posedge clk) begin
    if (store) begin
      if (count_r == '0) begin
        min_r <= in_tdata;
        max_r <= in_tdata;
      end else begin
        if ($signed(in_tdata) < $signed(min_r)) min_r <= in_tdata;
        if ($signed(in_tdata) > $signed(max_r)) max_r <= in_tdata;
      end
    end
  end

  // divider trial subtract of span << k
  assign trial = rem_r - (NUM_W'(span_r) << k_r);
  assign q_bit = (rem_r >= (NUM_W'(span_r) << k_r));

  // difference is never negative since min <= x <= max
  always_ff @(posedge clk) begin
    if (cmd.rd) span_r <= max_r - min_r;
    if (cmd.sub) diff_r <= rd_data - min_r;
    if (cmd.scale) begin
      rem_r <= {diff_r, {PIXEL_W{1'b0}}} - NUM_W'(diff_r);
      q_r   <= '0;
    end else if (cmd.step) begin
      if (q_bit) rem_r <= trial;
      q_r <= {q_r[PIXEL_W-2:0], q_bit};
    end
  end

  // mode 1: trunc(q - 128) toward zero, then inverted
  assign t_inc = !q_r[PIXEL_W-1] && (rem_r != '0);
  assign t_val = {1'b0, q_r} - (PIXEL_W+1)'(Q_MID) + (PIXEL_W+1)'(t_inc);

  always_comb begin
    if (span_r == '0) begin
      pix = '0;
    end else if (mode_r == MODE_INVERT) begin
      pix = ~t_val[PIXEL_W-1:0];
    end else begin
      pix = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fmt) begin
      out_tdata <= pix;
      out_tlast <= sts.last_elem;
    end
  end

  assign sts.last_elem = ((idx_r + CW'(1)) == count_r);
  assign sts.div_done  = (k_r == '0);

endmodule

`default_nettype wire

>>> sv/mmcs_chk.sv
// ----------------------------------------------------------------------------
// mmcs_chk - port-level checks for the contrast stretch block
// Load/emit phase ordering, output hold under stall and no result after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcs_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic in_tlast,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic out_tlast
);

  // stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // never loading and emitting at once
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("load and emit overlap");

  // frame close stops loading
  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after frame end");

  // last pixel taken returns to loading
  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("no return to load after last pixel");

  // reset leaves no pending result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind min_max_contrast_stretch mmcs_chk u_mmcs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast)
);

`default_nettype wire

>>> sim/min_max_contrast_stretch_test.sv
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_test - self-checking bench for the contrast stretch
// Loads frames of Q16.16 samples under both output modes and checks every
// emitted pixel against its typed-in value or the bench's min/max stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_contrast_stretch_test;
  import mmcs_pkg::*;

  localparam int N_ITEMS       = 410;   // stored samples to aim for
  localparam int IDLE_PCT      = 24;    // per-side idle chance, percent
  localparam int SETTLE_CYCLES = 20;    // outlasts one result's latency
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int STALL_LIMIT   = 4000;  // cycles with no beat before giving up

  // one directed row; pix is the typed-in pixel this sample turns into
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                mode;
    bit                  typed;
    logic [PIXEL_W-1:0]  pix;
  } stim_row_t;

  // a sample held in the bench's copy of the frame buffer
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    bit                         typed;
    logic [PIXEL_W-1:0]         pix;
  } held_sample_t;

  typedef struct {
    logic [PIXEL_W-1:0] pix;
    logic               last;
  } pixel_beat_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata;   // [31:0] sample
  logic                in_tlast;   // last_sample
  logic                out_tvalid;
  logic                out_tready;
  logic [PIXEL_W-1:0]  out_tdata;  // [7:0] pixel
  logic                out_tlast;  // last_pixel
  logic                cfg_wr_en;
  logic                cfg_wr_data; // output_mode

  // side info travelling with the beat on offer (bench only)
  bit                  beat_typed;
  logic [PIXEL_W-1:0]  beat_pix;

  // bench copy of the block's state
  held_sample_t               frame_store[$];
  logic signed [SAMPLE_W-1:0] frame_lo;
  logic signed [SAMPLE_W-1:0] frame_hi;
  logic                       mode_shadow;
  pixel_beat_t                pending_pixels[$];

  // stimulus controls
  bit steady;         // no idling on either side
  bit hold_off_req;   // receiver to hold off for HOLD_CYCLES

  int errors;
  int samples_stored;
  int samples_dropped;
  int frames_done;
  int pixels_checked;
  int mode_writes;
  int stall_cycles;

  logic [SAMPLE_W-1:0] corner_vals [4] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                           32'h0000_0000, 32'hFFFF_FFFF};

  // Directed frames. Flat frames give 0 in both modes; the frame's min and
  // max give 0/255 plain, 0x7F/0x80 inverted; an exact midpoint of 128
  // gives 0xFF inverted. Untyped rows go through the predictor.
  stim_row_t dir_rows [20] = '{
    // single-sample frame is flat
    '{32'h7FFF_FFFF, 1'b1, MODE_PLAIN,  1'b1, 8'h00},
    // full-range span
    '{32'h8000_0000, 1'b0, MODE_PLAIN,  1'b1, 8'h00},
    '{32'h7FFF_FFFF, 1'b0, MODE_PLAIN,  1'b1, 8'hFF},
    '{32'h0000_0000, 1'b0, MODE_PLAIN,  1'b0, 8'h00},
    '{32'hFFFF_FFFF, 1'b1, MODE_PLAIN,  1'b0, 8'h00},
    // flat multi-sample frame
    '{32'h0000_0005, 1'b0, MODE_PLAIN,  1'b1, 8'h00},
    '{32'h0000_0005, 1'b0, MODE_PLAIN,  1'b1, 8'h00},
    '{32'h0000_0005, 1'b1, MODE_PLAIN,  1'b1, 8'h00},
    // inverted: -1.0 .. +1.0
    '{32'hFFFF_0000, 1'b0, MODE_INVERT, 1'b1, 8'h7F},
    '{32'h0001_0000, 1'b1, MODE_INVERT, 1'b1, 8'h80},
    // half-step below the center truncates toward zero
    '{32'h0000_0000, 1'b0, MODE_INVERT, 1'b1, 8'h7F},
    '{32'h0000_0002, 1'b0, MODE_INVERT, 1'b1, 8'h80},
    '{32'h0000_0001, 1'b1, MODE_INVERT, 1'b0, 8'h00},
    // exact center
    '{32'h0000_0000, 1'b0, MODE_INVERT, 1'b1, 8'h7F},
    '{32'h0000_00FF, 1'b0, MODE_INVERT, 1'b1, 8'h80},
    '{32'h0000_0080, 1'b1, MODE_INVERT, 1'b1, 8'hFF},
    // full range, inverted
    '{32'h8000_0000, 1'b0, MODE_INVERT, 1'b1, 8'h7F},
    '{32'h7FFF_FFFF, 1'b0, MODE_INVERT, 1'b1, 8'h80},
    '{32'h1234_5678, 1'b1, MODE_INVERT, 1'b0, 8'h00},
    // flat single sample, inverted
    '{32'h8000_0000, 1'b1, MODE_INVERT, 1'b1, 8'h00}
  };

  min_max_contrast_stretch dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor((x-lo)*255/(hi-lo)); inverted mode centers on 128, truncates
  // toward zero and flips the bits
  function automatic logic [PIXEL_W-1:0] stretch_pixel(
      input logic signed [SAMPLE_W-1:0] x,
      input logic signed [SAMPLE_W-1:0] lo,
      input logic signed [SAMPLE_W-1:0] hi,
      input logic                       mode);
    logic signed [63:0] span;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    logic signed [63:0] rem;
    logic signed [63:0] t;
    if (hi == lo) return '0;
    span = 64'(hi) - 64'(lo);
    num  = (64'(x) - 64'(lo)) * 255;
    quo  = num / span;
    rem  = num % span;
    if (mode == MODE_PLAIN) return quo[PIXEL_W-1:0];
    t = quo - Q_MID;
    if (t < 0 && rem != 0) t = t + 1;
    return ~t[PIXEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (pixel #%0d, frame #%0d)",
             what, got, want, pixels_checked, frames_done);
    errors++;
  endtask

  // Offer one sample; random idle cycles ahead of it unless steady.
  // Returns at the falling edge after the beat was taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic l,
                             input bit typed, input logic [PIXEL_W-1:0] pix);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= s;
    in_tlast   <= l;
    beat_typed <= typed;
    beat_pix   <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender pauses until every pixel is back, lets the divider pipe settle,
  // then writes the mode register for one cycle.
  task automatic set_output_mode(input logic m);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the block on every accepted beat. Values sampled at
  // the rising edge are the pre-edge ones, so no race with the block.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    held_sample_t h;
    pixel_beat_t  e;
    int           n;
    if (rst_n) begin
      if (cfg_wr_en) begin
        mode_shadow = cfg_wr_data;
        mode_writes++;
      end

      if (in_tvalid && in_tready) begin
        if (frame_store.size() < DEF_FRAME_DEPTH) begin
          // first sample seeds both bounds
          if (frame_store.size() == 0) begin
            frame_lo = in_tdata;
            frame_hi = in_tdata;
          end else begin
            if ($signed(in_tdata) < frame_lo) frame_lo = in_tdata;
            if ($signed(in_tdata) > frame_hi) frame_hi = in_tdata;
          end
          h.sample = in_tdata;
          h.typed  = beat_typed;
          h.pix    = beat_pix;
          frame_store.push_back(h);
          samples_stored++;
        end else begin
          samples_dropped++;  // buffer full: not stored, not in min/max
        end

        // tlast closes the frame: queue one pixel per stored sample
        if (in_tlast) begin
          n = frame_store.size();
          for (int i = 0; i < n; i++) begin
            e.pix  = frame_store[i].typed ? frame_store[i].pix :
                     stretch_pixel(frame_store[i].sample, frame_lo, frame_hi, mode_shadow);
            e.last = (i == n - 1);
            pending_pixels.push_back(e);
          end
          frame_store.delete();
          frames_done++;
        end
      end

      if (out_tvalid && out_tready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("pixel with nothing pending", out_tdata, -1);
        end else begin
          e = pending_pixels.pop_front();
          if (out_tdata !== e.pix) report_mismatch("pixel", out_tdata, e.pix);
          if (out_tlast !== e.last) report_mismatch("last_pixel", out_tlast, e.last);
        end
        pixels_checked++;
      end
    end
  end

  // Receiver: random backpressure, a steady stretch, and one long hold-off
  // counted here while the sender keeps offering.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: gives up with an error once the stall counter, cleared by any beat on either side, hits its limit
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no beat for %0d cycles, %0d pixels pending",
             STALL_LIMIT, pending_pixels.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                  phase;
    int                  n_frames;
    int                  len;
    int                  style;
    int                  r;
    bit                  hold;
    logic                m;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] s;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = MODE_PLAIN;
    beat_typed   = 1'b0;
    beat_pix     = '0;
    mode_shadow  = MODE_PLAIN;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    errors       = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // explicit write of the reset value, then the directed table
    set_output_mode(MODE_PLAIN);
    for (int i = 0; i < $size(dir_rows); i++) begin
      // mode changes only land on a frame boundary
      if (dir_rows[i].mode != mode_shadow && frame_store.size() == 0)
        set_output_mode(dir_rows[i].mode);
      send_sample(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].typed,
                  dir_rows[i].pix);
    end

    // Random phases of several frames each, one mode per phase. Phase 0
    // opens with a full frame under a long receiver hold-off; phase 1 runs
    // with no idling at all.
    phase = 0;
    while (samples_stored < N_ITEMS) begin
      m = (phase == 0) ? MODE_INVERT :
          (phase == 1) ? MODE_PLAIN  : logic'($urandom_range(0, 1));
      set_output_mode(m);
      steady   = (phase == 1);
      n_frames = $urandom_range(4, 10);
      for (int f = 0; f < n_frames; f++) begin
        hold = (phase == 0 && f == 0);
        r    = $urandom_range(0, 99);
        if (hold || r < 3)
          len = DEF_FRAME_DEPTH;
        else if (r < 5)
          len = DEF_FRAME_DEPTH + $urandom_range(1, 8);  // overfull, tail dropped
        else if (r < 10)
          len = $urandom_range(9, 40);
        else
          len = $urandom_range(1, 8);

        // value styles: wide random, tight cluster, flat, corners mixed in
        style = $urandom_range(0, 3);
        base  = $urandom();
        for (int k = 0; k < len; k++) begin
          case (style)
            0: s = $urandom();
            1: s = base + $urandom_range(0, 15);
            2: s = base;
            default: begin
              s = $urandom_range(0, 1) ? corner_vals[$urandom_range(0, 3)] : $urandom();
            end
          endcase
          if (hold && k == len - 1) hold_off_req = 1'b1;
          send_sample(s, k == len - 1, 1'b0, '0);
        end
      end
      steady = 1'b0;
      phase++;
    end

    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d frames, %0d samples stored, %0d dropped past full buffer",
             frames_done, samples_stored, samples_dropped);
    $display("checked %0d pixels over %0d mode writes, %0d mismatches",
             pixels_checked, mode_writes, errors);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
